// File: design/kct_pkg.sv
package kct_pkg;

	// Request codes.
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_ADJUST = 2'd2;
	localparam logic [1:0] OP_ZEROS  = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_DUPLICATE = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	localparam int DATA_W = 32;
	localparam int ZERO_W = 8;

	typedef struct packed {
		logic [1:0]               operation;
		logic signed [DATA_W-1:0] key;
		logic signed [DATA_W-1:0] amount;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] count_value;
		logic [ZERO_W-1:0]        zero_entries;
	} rsp_t;

	// Controller to datapath.
	typedef struct packed {
		logic start;
		logic scan;
		logic commit;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic done;
	} stat_t;

endpackage

// File: design/kct_ram.sv
module kct_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: design/kct_ctrl.sv
module kct_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	input  kct_pkg::stat_t  stat,
	output kct_pkg::cmd_t   cmd
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   rsp_valid_q;

	assign req_stall  = (state_q != S_IDLE);
	assign cmd.start  = (state_q == S_IDLE) && req_valid;
	assign cmd.scan   = (state_q == S_SCAN);
	// The result register is free when empty or being drained this cycle.
	assign cmd.commit = (state_q == S_FINISH) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.done) begin
					state_nxt = S_FINISH;
				end
			end
			S_FINISH: begin
				if (cmd.commit) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// File: design/kct_dp.sv
module kct_dp #(
	parameter int CAPACITY = 128
) (
	input  logic           clk,
	input  logic           arst_n,
	input  kct_pkg::cmd_t  cmd,
	input  kct_pkg::req_t  req,
	output kct_pkg::stat_t stat,
	output kct_pkg::rsp_t  rsp
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	kct_pkg::req_t req_q;
	kct_pkg::rsp_t rsp_q;
	kct_pkg::rsp_t rsp_nxt;

	logic [CNT_W-1:0]            used_q;
	logic [CNT_W-1:0]            rd_ptr_q;
	logic                        vld_s1;
	logic [IDX_W-1:0]            idx_s1;
	logic                        hit_q;
	logic [IDX_W-1:0]            hit_idx_q;
	logic [kct_pkg::DATA_W-1:0]  hit_cnt_q;
	logic [kct_pkg::ZERO_W-1:0]  zeros_q;

	logic [kct_pkg::DATA_W-1:0]  key_rd;
	logic [kct_pkg::DATA_W-1:0]  cnt_rd;

	logic is_ins, is_lookup, is_adj, is_zeros;
	logic full, issue, match_now, drained;
	logic key_we, cnt_we;
	logic [IDX_W-1:0]            cnt_waddr;
	logic [kct_pkg::DATA_W-1:0]  cnt_wdata;
	logic [kct_pkg::DATA_W-1:0]  adj_amt;

	assign is_ins    = (req_q.operation == kct_pkg::OP_INSERT);
	assign is_lookup = (req_q.operation == kct_pkg::OP_LOOKUP);
	assign is_adj    = (req_q.operation == kct_pkg::OP_ADJUST);
	assign is_zeros  = (req_q.operation == kct_pkg::OP_ZEROS);

	assign full = (used_q == CNT_W'(CAPACITY));

	// First match in insertion order: stop comparing once a hit is held.
	assign match_now = cmd.scan && vld_s1 && !hit_q && !is_zeros
		&& (key_rd == req_q.key);
	assign issue = cmd.scan && !hit_q && !match_now && (rd_ptr_q != used_q)
		&& !(is_ins && full);
	assign drained = (rd_ptr_q == used_q) && !vld_s1;

	assign stat.done = (is_ins && full) || hit_q || drained;

	assign adj_amt = is_adj ? req_q.amount : '0;

	assign key_we    = cmd.commit && is_ins && !full && !hit_q;
	assign cnt_we    = key_we || (cmd.commit && is_adj && hit_q);
	assign cnt_waddr = is_ins ? used_q[IDX_W-1:0] : hit_idx_q;
	assign cnt_wdata = is_ins ? req_q.amount : hit_cnt_q;

	kct_ram #(
		.WIDTH(kct_pkg::DATA_W),
		.DEPTH(CAPACITY)
	) u_key_ram (
		.clk     (clk),
		.wr_en   (key_we),
		.wr_addr (used_q[IDX_W-1:0]),
		.wr_data (req_q.key),
		.rd_en   (issue),
		.rd_addr (rd_ptr_q[IDX_W-1:0]),
		.rd_data (key_rd)
	);

	kct_ram #(
		.WIDTH(kct_pkg::DATA_W),
		.DEPTH(CAPACITY)
	) u_cnt_ram (
		.clk     (clk),
		.wr_en   (cnt_we),
		.wr_addr (cnt_waddr),
		.wr_data (cnt_wdata),
		.rd_en   (issue),
		.rd_addr (rd_ptr_q[IDX_W-1:0]),
		.rd_data (cnt_rd)
	);

	always_comb begin
		rsp_nxt.status       = kct_pkg::ST_OK;
		rsp_nxt.count_value  = '0;
		rsp_nxt.zero_entries = '0;
		if (is_ins) begin
			if (full) begin
				rsp_nxt.status = kct_pkg::ST_FULL;
			end else if (hit_q) begin
				rsp_nxt.status = kct_pkg::ST_DUPLICATE;
			end
		end else if (is_lookup || is_adj) begin
			if (hit_q) begin
				rsp_nxt.count_value = hit_cnt_q;
			end else begin
				rsp_nxt.status = kct_pkg::ST_NOT_FOUND;
			end
		end else begin
			rsp_nxt.zero_entries = zeros_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= '0;
			rd_ptr_q <= '0;
			vld_s1   <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			if (cmd.start) begin
				rd_ptr_q <= '0;
				vld_s1   <= 1'b0;
				hit_q    <= 1'b0;
			end else begin
				vld_s1 <= issue;
				if (issue) begin
					rd_ptr_q <= rd_ptr_q + CNT_W'(1);
				end
				if (match_now) begin
					hit_q <= 1'b1;
				end
			end
			if (key_we) begin
				used_q <= used_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q   <= req;
			zeros_q <= '0;
		end else if (cmd.scan && vld_s1 && is_zeros && (cnt_rd == '0)
				&& (zeros_q != '1)) begin
			zeros_q <= zeros_q + kct_pkg::ZERO_W'(1);
		end
		if (issue) begin
			idx_s1 <= rd_ptr_q[IDX_W-1:0];
		end
		if (match_now) begin
			hit_idx_q <= idx_s1;
			hit_cnt_q <= cnt_rd + adj_amt;
		end
		if (cmd.commit) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp = rsp_q;

endmodule

// File: design/keyed_count_table_unit.sv
// Sequence: a request's result beat follows a scan over the stored entries; a key hit ends
// the scan early, and an insert into a full table reads no entries. A new request is taken in
// only once the previous one has committed its result. The scan reads one entry per cycle
// through the single read port of each table RAM.
// Reset: arst_n clears the entry count and all control state; table contents are not cleared.
module keyed_count_table_unit #(
	parameter int CAPACITY = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  kct_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output kct_pkg::rsp_t rsp
);

	// The controller sequences each request through a scan and a commit step.
	// The datapath holds the request, the key and count RAMs, the entry count,
	// and the result register that lets a finished beat wait while the next
	// request is already taken in.
	kct_pkg::cmd_t  cmd;
	kct_pkg::stat_t stat;

	kct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The scan reads both RAMs at the same address, so on a key hit the
	// matching count is already at hand and an adjust writes it back in the
	// commit cycle. Count-zero requests use the same scan over the counts.
	kct_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule
